/* hdl/kmc_pkg.sv */
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types and constants of the weighted k-means clustering block.
// ----------------------------------------------------------------------------
package kmc_pkg;

  localparam int LANES      = 4;
  localparam int LANE_W     = 16;
  localparam int PT_W       = LANES * LANE_W;
  localparam int LBL_W      = 4;
  localparam int IDX_W      = 6;
  localparam int DIST_W     = 64;
  localparam int INERTIA_W  = 48;
  localparam int DIST_SHIFT = 28;

  localparam logic signed [15:0] WEIGHT_Q14 = 16'sd19661;

  localparam logic [0:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [0:0] REG_MAX_ITER     = 1'b1;

  typedef enum logic [1:0] {
    M_LOAD    = 2'd0,
    M_ASSIGN  = 2'd1,
    M_MEMBER  = 2'd2,
    M_MEASURE = 2'd3
  } mode_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    mode_t             mode;
    logic [IDX_W-1:0]  idx;
    logic [LBL_W-1:0]  label;
    logic              have;
    logic [LBL_W-1:0]  best;
    logic [DIST_W-1:0] dsq;
    logic [PT_W-1:0]   point;
  } tok_t;

  typedef struct packed {
    logic clr;
    logic div_start;
  } cell_ctl_t;

endpackage

/* hdl/weighted_kmeans_clustering.sv */
// ----------------------------------------------------------------------------
// weighted_kmeans_clustering
// Lloyd k-means over a batch of points on a chain of centroid cells.
//
// Points enter on the s_ stream, one per cycle while s_tready is high; the
// transaction with s_tlast set closes the batch and starts clustering, and
// s_tready stays low until the last label has been handed to the output
// register. Each centroid sits in its own cell; a point passes the chain of
// MAX_CLUSTERS cells, five stages each, and leaves it with its nearest label.
// Start-up loads the centroids; each round runs an assign pass, a member
// pass and the bit-serial mean divider in every cell (SUM_W = 23 at the
// default size). An inertia pass follows the last round. Labels then
// leave on the m_ stream in load order, with m_tlast on the final point;
// the next label is read only once the previous one has been taken, so a
// stalled receiver holds the output register and the label reader waits.
// Loading of the next batch starts as soon as the last label sits in the
// output register.
// Reset is synchronous; it empties the batch, sets K = 2 and a limit of 100
// rounds. Configuration is written through cfg_we, cfg_addr and cfg_data.
// ----------------------------------------------------------------------------
module weighted_kmeans_clustering #(
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORDS       = 4,
  parameter int COORD_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_0, coord_1, coord_2, coord_3
  input  logic        s_tlast,   // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // cluster, inertia, zero fill
  output logic        m_tlast,   // last_label
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [9:0]  cfg_data
);

  localparam int LANES  = kmc_pkg::LANES;
  localparam int LANE_W = kmc_pkg::LANE_W;
  localparam int PT_W   = kmc_pkg::PT_W;
  localparam int LBL_W  = kmc_pkg::LBL_W;
  localparam int K_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PA_W   = $clog2(MAX_POINTS);
  localparam int FMAX   = (MAX_POINTS > MAX_CLUSTERS) ? MAX_POINTS : MAX_CLUSTERS;
  localparam int F_W    = $clog2(FMAX + 1);
  localparam int SUM_W  = LANE_W + $clog2(MAX_POINTS) + 1;
  localparam int DIV_CYC = SUM_W + 4;
  localparam int D_W    = $clog2(DIV_CYC + 1);

  typedef enum logic [6:0] {
    S_LOAD    = 7'b0000001,
    S_INIT    = 7'b0000010,
    S_ASSIGN  = 7'b0000100,
    S_MEMBER  = 7'b0001000,
    S_DIVIDE  = 7'b0010000,
    S_MEASURE = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t state;

  logic [4:0]  num_clusters;
  logic [9:0]  max_iterations;
  logic [K_W-1:0] k;

  logic [PT_W-1:0]  pmem [MAX_POINTS];
  logic [LBL_W-1:0] lmem [MAX_POINTS];
  logic [PT_W-1:0]  pdata;
  logic [LBL_W-1:0] ldata;
  logic [PA_W-1:0]  raddr;
  logic [PT_W-1:0]  pin;

  logic [CNT_W-1:0] npts;
  logic [CNT_W-1:0] oi;
  logic             rd_pend;
  logic [F_W-1:0]   fi;
  logic [F_W-1:0]   flim;
  logic             feeding;
  kmc_pkg::mode_t   fmode;
  logic             fresh;
  logic             changed;
  logic [9:0]       iter;
  logic [D_W-1:0]   dcnt;
  logic [kmc_pkg::INERTIA_W-1:0] inertia;
  logic [kmc_pkg::INERTIA_W:0]   isum;

  logic             a_valid;
  logic             a_last;
  logic             a_zero;
  kmc_pkg::mode_t   a_mode;
  logic [F_W-1:0]   a_idx;

  kmc_pkg::cell_ctl_t ctl;
  kmc_pkg::tok_t      feed_tok;
  kmc_pkg::tok_t      tk [MAX_CLUSTERS+1];
  kmc_pkg::tok_t      tend;
  logic               pass_end;

  assign s_tready = (state == S_LOAD);
  assign tk[0]    = feed_tok;
  assign tend     = tk[MAX_CLUSTERS];
  assign pass_end = tend.valid && tend.last;
  assign isum     = {1'b0, inertia} + (kmc_pkg::INERTIA_W + 1)'(tend.dsq[63:kmc_pkg::DIST_SHIFT]);

  for (genvar c = 0; c < LANES; c++) begin : g_pin
    if (c < COORDS) begin : g_used
      assign pin[c*LANE_W +: LANE_W] = LANE_W'($signed(s_tdata[c*LANE_W +: COORD_WIDTH]));
    end else begin : g_unused
      assign pin[c*LANE_W +: LANE_W] = '0;
    end
  end

  always_comb begin
    if (num_clusters == '0) begin
      k = K_W'(1);
    end else if (32'(num_clusters) > MAX_CLUSTERS) begin
      k = K_W'(MAX_CLUSTERS);
    end else begin
      k = K_W'(num_clusters);
    end
  end

  always_comb begin
    if (state == S_OUT) begin
      raddr = PA_W'(oi);
    end else if (fmode == kmc_pkg::M_LOAD && (32'(fi) >= 32'(npts))) begin
      raddr = '0;
    end else begin
      raddr = PA_W'(fi);
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters   <= 5'd2;
      max_iterations <= 10'd100;
    end else if (cfg_we) begin
      case (cfg_addr)
        kmc_pkg::REG_NUM_CLUSTERS: num_clusters   <= cfg_data[4:0];
        kmc_pkg::REG_MAX_ITER:     max_iterations <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (state == S_LOAD && s_tvalid && 32'(npts) < MAX_POINTS) begin
      pmem[PA_W'(npts)] <= pin;
    end
    pdata <= pmem[raddr];
  end

  always_ff @(posedge clk) begin
    if (tend.valid && tend.mode == kmc_pkg::M_ASSIGN) begin
      lmem[PA_W'(tend.idx)] <= tend.best;
    end
    ldata <= lmem[raddr];
  end

  // feeder
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      feed_tok <= '0;
    end else begin
      a_valid <= feeding;
      a_last  <= (fi == flim - 1'b1);
      a_mode  <= fmode;
      a_idx   <= fi;
      a_zero  <= (fmode == kmc_pkg::M_LOAD)
              && ((32'(fi) >= 32'(npts)) || (32'(fi) >= 32'(k)));
      feed_tok.valid <= a_valid;
      feed_tok.last  <= a_last;
      feed_tok.mode  <= a_mode;
      feed_tok.idx   <= kmc_pkg::IDX_W'(a_idx);
      feed_tok.have  <= 1'b0;
      feed_tok.best  <= '0;
      feed_tok.dsq   <= '0;
      feed_tok.point <= a_zero ? '0 : pdata;
      if (a_mode == kmc_pkg::M_LOAD) begin
        feed_tok.label <= LBL_W'(a_idx);
      end else begin
        feed_tok.label <= fresh ? '0 : ldata;
      end
    end
  end

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_cell
    kmc_cell #(
      .CELL_IDX    (i),
      .MAX_POINTS  (MAX_POINTS),
      .MAX_CLUSTERS(MAX_CLUSTERS),
      .COORDS      (COORDS)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .k    (k),
      .tok_i(tk[i]),
      .tok_o(tk[i+1])
    );
  end

  // cell control pulses
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.clr       <= (state == S_ASSIGN) && pass_end;
      ctl.div_start <= (state == S_MEMBER) && pass_end;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      npts     <= '0;
      feeding  <= 1'b0;
      fi       <= '0;
      flim     <= '0;
      fmode    <= kmc_pkg::M_LOAD;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
      oi       <= '0;
      fresh    <= 1'b1;
      changed  <= 1'b0;
      iter     <= '0;
      dcnt     <= '0;
      inertia  <= '0;
    end else begin
      if (feeding) begin
        fi <= fi + 1'b1;
        if (fi == flim - 1'b1) begin
          feeding <= 1'b0;
        end
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (tend.valid && tend.mode == kmc_pkg::M_ASSIGN && tend.best != tend.label) begin
        changed <= 1'b1;
      end
      if (tend.valid && tend.mode == kmc_pkg::M_MEASURE) begin
        inertia <= isum[kmc_pkg::INERTIA_W] ? '1 : isum[kmc_pkg::INERTIA_W-1:0];
      end

      case (state)
        S_LOAD: begin
          if (s_tvalid) begin
            if (32'(npts) < MAX_POINTS) begin
              npts <= npts + 1'b1;
            end
            if (s_tlast) begin
              state   <= S_INIT;
              feeding <= 1'b1;
              fi      <= '0;
              flim    <= F_W'(MAX_CLUSTERS);
              fmode   <= kmc_pkg::M_LOAD;
              fresh   <= 1'b1;
            end
          end
        end
        S_INIT: begin
          if (pass_end) begin
            feeding <= 1'b1;
            fi      <= '0;
            flim    <= F_W'(npts);
            if (max_iterations == '0) begin
              state   <= S_MEASURE;
              fmode   <= kmc_pkg::M_MEASURE;
              inertia <= '0;
            end else begin
              state   <= S_ASSIGN;
              fmode   <= kmc_pkg::M_ASSIGN;
              iter    <= '0;
              changed <= 1'b0;
            end
          end
        end
        S_ASSIGN: begin
          if (pass_end) begin
            state   <= S_MEMBER;
            feeding <= 1'b1;
            fi      <= '0;
            fmode   <= kmc_pkg::M_MEMBER;
            fresh   <= 1'b0;
          end
        end
        S_MEMBER: begin
          if (pass_end) begin
            state <= S_DIVIDE;
            dcnt  <= '0;
          end
        end
        S_DIVIDE: begin
          dcnt <= dcnt + 1'b1;
          if (dcnt == D_W'(DIV_CYC - 1)) begin
            iter    <= iter + 1'b1;
            feeding <= 1'b1;
            fi      <= '0;
            if (!changed || ({1'b0, iter} + 11'd1 == {1'b0, max_iterations})) begin
              state   <= S_MEASURE;
              fmode   <= kmc_pkg::M_MEASURE;
              inertia <= '0;
            end else begin
              state   <= S_ASSIGN;
              fmode   <= kmc_pkg::M_ASSIGN;
              changed <= 1'b0;
            end
          end
        end
        S_MEASURE: begin
          if (pass_end) begin
            state   <= S_OUT;
            oi      <= '0;
            rd_pend <= 1'b0;
          end
        end
        S_OUT: begin
          if (rd_pend) begin
            rd_pend  <= 1'b0;
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, inertia, fresh ? {LBL_W{1'b0}} : ldata};
            m_tlast  <= (oi == npts);
            if (oi == npts) begin
              state <= S_LOAD;
              npts  <= '0;
            end
          end else if ((!m_tvalid || m_tready) && oi < npts) begin
            rd_pend <= 1'b1;
            oi      <= oi + 1'b1;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_rise_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("output loaded outside the output phase");

  a_chain_phase: assert property (@(posedge clk) disable iff (rst)
    tend.valid |-> (state == S_INIT || state == S_ASSIGN
                    || state == S_MEMBER || state == S_MEASURE))
    else $error("chain token leaves outside a pass");

  a_label_range: assert property (@(posedge clk) disable iff (rst)
    (tend.valid && tend.mode == kmc_pkg::M_ASSIGN) |-> (32'(tend.best) < 32'(k)))
    else $error("assigned label beyond active clusters");

  a_no_feed_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> !feeding)
    else $error("point accepted while a pass is being fed");

endmodule

/* hdl/kmc_cell.sv */
// ----------------------------------------------------------------------------
// kmc_cell
// One centroid cell: holds a centroid and its member sums, measures the
// passing point, updates the running best and divides its sums into a mean.
// ----------------------------------------------------------------------------
module kmc_cell #(
  parameter int CELL_IDX     = 0,
  parameter int MAX_POINTS   = 64,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORDS       = 4,
  localparam int K_W = $clog2(MAX_CLUSTERS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  kmc_pkg::cell_ctl_t ctl,
  input  logic [K_W-1:0]     k,
  input  kmc_pkg::tok_t      tok_i,
  output kmc_pkg::tok_t      tok_o
);

  localparam int LANES  = kmc_pkg::LANES;
  localparam int LANE_W = kmc_pkg::LANE_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = LANE_W + $clog2(MAX_POINTS) + 1;
  localparam int STEP_W = $clog2(SUM_W + 1);

  kmc_pkg::tok_t t1, t2, t3, t4, t5;
  kmc_pkg::tok_t t4_next;

  logic signed [16:0] diff [LANES];
  logic signed [33:0] mid  [LANES];
  logic [63:0]        term [LANES];
  logic [63:0]        dsum;

  logic [kmc_pkg::PT_W-1:0] cent;
  logic signed [SUM_W-1:0]  sum [LANES];
  logic [CNT_W-1:0]         cnt;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [LANES-1:0]    neg;
  logic [SUM_W-1:0]    mag      [LANES];
  logic [CNT_W:0]      rem      [LANES];
  logic [CNT_W:0]      remt     [LANES];
  logic [SUM_W-1:0]    mag_next [LANES];
  logic [CNT_W:0]      rem_next [LANES];

  logic match_in;
  logic active;

  assign match_in = tok_i.valid && (tok_i.label == kmc_pkg::LBL_W'(CELL_IDX));
  assign active   = K_W'(CELL_IDX) < k;
  assign tok_o    = t5;

  always_comb begin
    dsum = '0;
    for (int c = 0; c < LANES; c++) begin
      dsum = dsum + term[c];
    end
  end

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      remt[c] = {rem[c][CNT_W-1:0], mag[c][SUM_W-1]};
      if (remt[c] >= {1'b0, cnt}) begin
        rem_next[c] = remt[c] - {1'b0, cnt};
        mag_next[c] = {mag[c][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[c] = remt[c];
        mag_next[c] = {mag[c][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    t4_next = t3;
    if (t3.valid) begin
      case (t3.mode)
        kmc_pkg::M_ASSIGN: begin
          if (active && (!t3.have || dsum < t3.dsq)) begin
            t4_next.have = 1'b1;
            t4_next.best = kmc_pkg::LBL_W'(CELL_IDX);
            t4_next.dsq  = dsum;
          end
        end
        kmc_pkg::M_MEMBER, kmc_pkg::M_MEASURE: begin
          if (t3.label == kmc_pkg::LBL_W'(CELL_IDX)) begin
            t4_next.dsq = dsum;
          end
        end
        default: ;
      endcase
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
    end else begin
      t1 <= tok_i;
      t2 <= t1;
      t3 <= t2;
      t4 <= t4_next;
      t5 <= t4;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < LANES; c++) begin
      if (c < COORDS) begin
        diff[c] <= 17'($signed(tok_i.point[c*LANE_W +: LANE_W]))
                 - 17'($signed(cent[c*LANE_W +: LANE_W]));
      end else begin
        diff[c] <= '0;
      end
      if (c == 1) begin
        mid[c] <= 34'(diff[c]) * 34'(kmc_pkg::WEIGHT_Q14);
        term[c] <= 64'($unsigned(68'(mid[c]) * 68'(mid[c])));
      end else begin
        mid[c] <= 34'(diff[c]) * 34'(diff[c]);
        term[c] <= 64'($unsigned(mid[c])) << kmc_pkg::DIST_SHIFT;
      end
    end
  end

  // member sums and counts
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      cnt <= '0;
      for (int c = 0; c < LANES; c++) begin
        sum[c] <= '0;
      end
    end else if (match_in && tok_i.mode == kmc_pkg::M_MEMBER) begin
      cnt <= cnt + 1'b1;
      for (int c = 0; c < LANES; c++) begin
        sum[c] <= sum[c] + SUM_W'($signed(tok_i.point[c*LANE_W +: LANE_W]));
      end
    end
  end

  // mean division, one quotient bit per cycle on every lane
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctl.div_start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == STEP_W'(SUM_W)) begin
        busy <= 1'b0;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.div_start) begin
      for (int c = 0; c < LANES; c++) begin
        neg[c] <= sum[c][SUM_W-1];
        mag[c] <= sum[c][SUM_W-1] ? SUM_W'(-sum[c]) : SUM_W'(sum[c]);
        rem[c] <= '0;
      end
    end else if (busy && step != STEP_W'(SUM_W)) begin
      for (int c = 0; c < LANES; c++) begin
        mag[c] <= mag_next[c];
        rem[c] <= rem_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (match_in && tok_i.mode == kmc_pkg::M_LOAD) begin
      cent <= tok_i.point;
    end else if (busy && step == STEP_W'(SUM_W)) begin
      for (int c = 0; c < LANES; c++) begin
        if (cnt == '0) begin
          cent[c*LANE_W +: LANE_W] <= '0;
        end else if (neg[c]) begin
          cent[c*LANE_W +: LANE_W] <= LANE_W'(-mag[c][LANE_W-1:0]);
        end else begin
          cent[c*LANE_W +: LANE_W] <= mag[c][LANE_W-1:0];
        end
      end
    end
  end

endmodule
